// ----- design/rcl_pkg.sv -----
// Shared constants, stage map and coefficients for the RGB to CIELAB converter.
package rcl_pkg;

    localparam int FRACTION_BITS = 15;
    localparam int CH_W          = 16;
    localparam int COEF_BITS     = 20;
    localparam int F_BITS        = 16;
    localparam int ACC_W         = 38;
    localparam int T_W           = ACC_W - COEF_BITS;
    localparam int CB_BITS       = (T_W + 3 * F_BITS - FRACTION_BITS) / 3;
    localparam int N_W           = T_W + 3 * F_BITS - FRACTION_BITS;
    localparam int F_W           = CB_BITS + 1;
    localparam int MAG_W         = 27;
    localparam int Q_W           = 20;

    localparam int MAT_STAGES = 2;
    localparam int LAB_STAGES = CB_BITS + 2;
    localparam int SCL_STAGES = 3;
    localparam int ST_MAT     = 0;
    localparam int ST_LAB     = ST_MAT + MAT_STAGES;
    localparam int ST_SCL     = ST_LAB + LAB_STAGES;
    localparam int NSTAGE     = ST_SCL + SCL_STAGES;

    localparam longint unsigned WX_DEN = 64'd9504670;
    localparam longint unsigned WY_DEN = 64'd10000000;
    localparam longint unsigned WZ_DEN = 64'd10889690;

    localparam logic [COEF_BITS-1:0] C_XR =
        COEF_BITS'(((64'd4124240 << COEF_BITS) + WX_DEN / 2) / WX_DEN);
    localparam logic [COEF_BITS-1:0] C_XG =
        COEF_BITS'(((64'd3575790 << COEF_BITS) + WX_DEN / 2) / WX_DEN);
    localparam logic [COEF_BITS-1:0] C_XB =
        COEF_BITS'(((64'd1804640 << COEF_BITS) + WX_DEN / 2) / WX_DEN);
    localparam logic [COEF_BITS-1:0] C_YR =
        COEF_BITS'(((64'd2126560 << COEF_BITS) + WY_DEN / 2) / WY_DEN);
    localparam logic [COEF_BITS-1:0] C_YG =
        COEF_BITS'(((64'd7151580 << COEF_BITS) + WY_DEN / 2) / WY_DEN);
    localparam logic [COEF_BITS-1:0] C_YB =
        COEF_BITS'(((64'd721856 << COEF_BITS) + WY_DEN / 2) / WY_DEN);
    localparam logic [COEF_BITS-1:0] C_ZR =
        COEF_BITS'(((64'd193324 << COEF_BITS) + WZ_DEN / 2) / WZ_DEN);
    localparam logic [COEF_BITS-1:0] C_ZG =
        COEF_BITS'(((64'd1191930 << COEF_BITS) + WZ_DEN / 2) / WZ_DEN);
    localparam logic [COEF_BITS-1:0] C_ZB =
        COEF_BITS'(((64'd9504440 << COEF_BITS) + WZ_DEN / 2) / WZ_DEN);

    // Linear segment: f = floor(A / 1000) with A = 15574 t + 9039946.
    localparam longint unsigned LIN_MAX   = (64'd8856 << FRACTION_BITS) / 64'd1000000;
    localparam int              LIN_T_W   = 9;
    localparam int              LIN_A_W   = 24;
    localparam logic [13:0]     LIN_SLOPE = 14'd15574;
    localparam logic [LIN_A_W-1:0] LIN_OFS = 24'd9039946;
    localparam int              LIN_SH    = 34;
    localparam logic [24:0]     LIN_RCP   = 25'((64'd1 << LIN_SH) / 64'd1000 + 64'd1);

    // Output scaling: q = floor((mag + 150) / 300).
    localparam int              SCL_SH    = 36;
    localparam logic [27:0]     SCL_RCP   = 28'((64'd1 << SCL_SH) / 64'd300 + 64'd1);
    localparam logic [7:0]      SCL_HALF  = 8'd150;

endpackage

// ----- design/rcl_flow.sv -----
// Valid bits and per-stage load enables of the conversion pipeline.
module rcl_flow import rcl_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_out_ready,
    output logic [NSTAGE-1:0] o_en,
    output logic              o_out_valid
);

    logic [NSTAGE-1:0] r_valid;
    logic [NSTAGE-1:0] n_valid;
    logic [NSTAGE:0]   w_go;

    always_comb begin
        w_go[NSTAGE] = i_out_ready;
        for (int k = NSTAGE - 1; k >= 0; k--) begin
            w_go[k] = !r_valid[k] || w_go[k+1];
        end
        for (int k = 0; k < NSTAGE; k++) begin
            if (w_go[k]) begin
                n_valid[k] = (k == 0) ? i_in_valid : r_valid[(k == 0) ? 0 : k - 1];
            end else begin
                n_valid[k] = r_valid[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= n_valid;
        end
    end

    assign o_en        = w_go[NSTAGE-1:0];
    assign o_out_valid = r_valid[NSTAGE-1];

endmodule

// ----- design/rcl_matrix.sv -----
// RGB to white-normalized XYZ matrix in two stages: products, then sums.
module rcl_matrix import rcl_pkg::*; (
    input  logic                  i_clk,
    input  logic [MAT_STAGES-1:0] i_en,
    input  logic [3*CH_W-1:0]     i_rgb,
    output logic [T_W-1:0]        o_tx,
    output logic [T_W-1:0]        o_ty,
    output logic [T_W-1:0]        o_tz
);

    localparam int P_W = COEF_BITS + CH_W;

    logic [COEF_BITS-1:0] w_coef [9];
    logic [P_W-1:0]       r_prod [9];
    logic [ACC_W-1:0]     w_acc  [3];
    logic [T_W-1:0]       r_t    [3];
    logic [CH_W-1:0]      w_ch   [3];

    assign w_coef = '{C_XR, C_XG, C_XB, C_YR, C_YG, C_YB, C_ZR, C_ZG, C_ZB};
    assign w_ch[0] = i_rgb[CH_W-1:0];
    assign w_ch[1] = i_rgb[2*CH_W-1:CH_W];
    assign w_ch[2] = i_rgb[3*CH_W-1:2*CH_W];

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            for (int k = 0; k < 9; k++) begin
                r_prod[k] <= P_W'(w_coef[k]) * P_W'(w_ch[k % 3]);
            end
        end
    end

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            w_acc[r] = (ACC_W'(1) << (COEF_BITS - 1)) + ACC_W'(r_prod[3*r])
                     + ACC_W'(r_prod[3*r+1]) + ACC_W'(r_prod[3*r+2]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            for (int r = 0; r < 3; r++) begin
                r_t[r] <= w_acc[r][ACC_W-1:COEF_BITS];
            end
        end
    end

    assign o_tx = r_t[0];
    assign o_ty = r_t[1];
    assign o_tz = r_t[2];

endmodule

// ----- design/rcl_lab_f.sv -----
// Lab companding function: pipelined rounded cube root beside the linear segment.
module rcl_lab_f import rcl_pkg::*; (
    input  logic                  i_clk,
    input  logic [LAB_STAGES-1:0] i_en,
    input  logic [T_W-1:0]        i_t,
    output logic [F_W-1:0]        o_f
);

    localparam int C2_W = 2 * CB_BITS + 2;
    localparam int W_W  = N_W + 5;

    logic [CB_BITS-1:0] r_c   [CB_BITS+1];
    logic [C2_W-1:0]    r_c2  [CB_BITS+1];
    logic [N_W:0]       r_c3  [CB_BITS+1];
    logic [N_W-1:0]     r_n   [CB_BITS+1];
    logic               r_lin [CB_BITS+1];
    logic [LIN_A_W-1:0] r_a;
    logic [13:0]        r_fl  [1:CB_BITS];
    logic [F_W-1:0]     r_f;
    logic [W_W-1:0]     w_h3;
    logic               w_up;

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_c[0]   <= '0;
            r_c2[0]  <= '0;
            r_c3[0]  <= '0;
            r_n[0]   <= {i_t, (N_W - T_W)'(0)};
            r_lin[0] <= (64'(i_t) <= LIN_MAX);
            r_a      <= LIN_A_W'(LIN_SLOPE) * LIN_A_W'(i_t[LIN_T_W-1:0]) + LIN_OFS;
        end
    end

    for (genvar g = 0; g < CB_BITS; g++) begin : g_root
        localparam int B = CB_BITS - 1 - g;
        logic [W_W-1:0] w_tri;
        logic           w_fit;
        logic [W_W-1:0] w_c2x3;
        logic [W_W-1:0] w_cx3;

        assign w_c2x3 = (W_W'(r_c2[g]) << 1) + W_W'(r_c2[g]);
        assign w_cx3  = (W_W'(r_c[g]) << 1) + W_W'(r_c[g]);
        assign w_tri  = W_W'(r_c3[g]) + (w_c2x3 << B) + (w_cx3 << (2 * B))
                      + (W_W'(1) << (3 * B));
        assign w_fit  = w_tri <= W_W'(r_n[g]);

        always_ff @(posedge i_clk) begin
            if (i_en[g+1]) begin
                r_n[g+1]   <= r_n[g];
                r_lin[g+1] <= r_lin[g];
                if (w_fit) begin
                    r_c[g+1]  <= r_c[g] | (CB_BITS'(1) << B);
                    r_c2[g+1] <= r_c2[g] + (C2_W'(r_c[g]) << (B + 1))
                               + (C2_W'(1) << (2 * B));
                    r_c3[g+1] <= (N_W+1)'(w_tri);
                end else begin
                    r_c[g+1]  <= r_c[g];
                    r_c2[g+1] <= r_c2[g];
                    r_c3[g+1] <= r_c3[g];
                end
            end
        end

        if (g == 0) begin : g_lin
            logic [LIN_A_W+24:0] w_lp;
            assign w_lp = (LIN_A_W+25)'(r_a) * (LIN_A_W+25)'(LIN_RCP);
            always_ff @(posedge i_clk) begin
                if (i_en[1]) begin
                    r_fl[1] <= 14'(w_lp >> LIN_SH);
                end
            end
        end else begin : g_carry
            always_ff @(posedge i_clk) begin
                if (i_en[g+1]) begin
                    r_fl[g+1] <= r_fl[g];
                end
            end
        end
    end

    assign w_h3 = (W_W'(r_c3[CB_BITS]) << 3) + (W_W'(r_c2[CB_BITS]) << 3)
                + (W_W'(r_c2[CB_BITS]) << 2) + (W_W'(r_c[CB_BITS]) << 2)
                + (W_W'(r_c[CB_BITS]) << 1) + W_W'(1);
    assign w_up = w_h3 <= (W_W'(r_n[CB_BITS]) << 3);

    always_ff @(posedge i_clk) begin
        if (i_en[LAB_STAGES-1]) begin
            if (r_lin[CB_BITS]) begin
                r_f <= F_W'(r_fl[CB_BITS]);
            end else begin
                r_f <= F_W'(r_c[CB_BITS]) + F_W'(w_up);
            end
        end
    end

    assign o_f = r_f;

endmodule

// ----- design/rcl_scale.sv -----
// Forms L, a and b, divides by 150 into Q1.15 and saturates.
module rcl_scale import rcl_pkg::*; (
    input  logic                  i_clk,
    input  logic [SCL_STAGES-1:0] i_en,
    input  logic [F_W-1:0]        i_fx,
    input  logic [F_W-1:0]        i_fy,
    input  logic [F_W-1:0]        i_fz,
    output logic [3*CH_W-1:0]     o_lab
);

    localparam int PR_W = MAG_W + 29;

    logic [MAG_W-1:0]  w_mag [3];
    logic              w_neg [3];
    logic [MAG_W-1:0]  r_mag [3];
    logic              r_neg [3];
    logic [Q_W-1:0]    r_q   [3];
    logic              r_qn  [3];
    logic [CH_W-1:0]   r_out [3];
    logic [MAG_W-1:0]  w_l;
    logic signed [F_W:0] w_da;
    logic signed [F_W:0] w_db;
    logic [F_W-1:0]    w_aa;
    logic [F_W-1:0]    w_ab;

    always_comb begin
        w_l  = MAG_W'(i_fy) * MAG_W'(116);
        w_da = $signed({1'b0, i_fx}) - $signed({1'b0, i_fy});
        w_db = $signed({1'b0, i_fy}) - $signed({1'b0, i_fz});
        w_aa = w_da[F_W] ? F_W'(-w_da) : F_W'(w_da);
        w_ab = w_db[F_W] ? F_W'(-w_db) : F_W'(w_db);
        w_neg[0] = w_l < (MAG_W'(16) << F_BITS);
        w_mag[0] = w_neg[0] ? (MAG_W'(16) << F_BITS) - w_l : w_l - (MAG_W'(16) << F_BITS);
        w_neg[1] = w_da[F_W];
        w_mag[1] = MAG_W'(w_aa) * MAG_W'(500);
        w_neg[2] = w_db[F_W];
        w_mag[2] = MAG_W'(w_ab) * MAG_W'(200);
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            if (i_en[0]) begin
                r_mag[k] <= w_mag[k];
                r_neg[k] <= w_neg[k];
            end
            if (i_en[1]) begin
                r_q[k]  <= Q_W'((PR_W'(r_mag[k] + MAG_W'(SCL_HALF)) * PR_W'(SCL_RCP))
                               >> SCL_SH);
                r_qn[k] <= r_neg[k];
            end
            if (i_en[2]) begin
                if (r_qn[k]) begin
                    r_out[k] <= (r_q[k] > Q_W'(32768)) ? 16'h8000 : CH_W'(-r_q[k]);
                end else begin
                    r_out[k] <= (r_q[k] > Q_W'(32767)) ? 16'h7FFF : CH_W'(r_q[k]);
                end
            end
        end
    end

    assign o_lab = {r_out[2], r_out[1], r_out[0]};

endmodule

// ----- design/rgb_to_cielab_scaled.sv -----
// Top level of the pipelined RGB to CIELAB (D65) converter with 1/150 scaling.
//
// One pixel enters on the slave stream as red, green and blue in unsigned
// Q1.15 and leaves on the master stream as lightness, green_red and
// blue_yellow in signed Q1.15, each being L, a or b divided by 150.
// Every accepted transfer yields exactly one output transfer, in order.
// The pipeline is 24 register stages deep; the 17-stage cube root sets most
// of that depth. One pixel is accepted every cycle unless a stalled receiver
// has filled the pipeline.
// Each stage carries its own valid bit, and a stage loads whenever it is
// empty or its successor moves, so a stalled receiver fills bubbles first
// and only then lowers the input ready; no pixel is dropped or repeated.
// Reset clears all valid bits; the output is not valid until a pixel has
// passed through.
module rgb_to_cielab_scaled import rcl_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_axis_tvalid,
    output logic              o_s_axis_tready,
    input  logic [3*CH_W-1:0] i_s_axis_tdata,   // red, green, blue
    output logic              o_m_axis_tvalid,
    input  logic              i_m_axis_tready,
    output logic [3*CH_W-1:0] o_m_axis_tdata    // lightness, green_red, blue_yellow
);

    logic [NSTAGE-1:0] w_en;
    logic [T_W-1:0]    w_tx;
    logic [T_W-1:0]    w_ty;
    logic [T_W-1:0]    w_tz;
    logic [F_W-1:0]    w_fx;
    logic [F_W-1:0]    w_fy;
    logic [F_W-1:0]    w_fz;

    rcl_flow u_flow (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .o_en        (w_en),
        .o_out_valid (o_m_axis_tvalid)
    );

    assign o_s_axis_tready = w_en[0];

    rcl_matrix u_matrix (
        .i_clk (i_clk),
        .i_en  (w_en[ST_MAT +: MAT_STAGES]),
        .i_rgb (i_s_axis_tdata),
        .o_tx  (w_tx),
        .o_ty  (w_ty),
        .o_tz  (w_tz)
    );

    rcl_lab_f u_fx (
        .i_clk (i_clk),
        .i_en  (w_en[ST_LAB +: LAB_STAGES]),
        .i_t   (w_tx),
        .o_f   (w_fx)
    );

    rcl_lab_f u_fy (
        .i_clk (i_clk),
        .i_en  (w_en[ST_LAB +: LAB_STAGES]),
        .i_t   (w_ty),
        .o_f   (w_fy)
    );

    rcl_lab_f u_fz (
        .i_clk (i_clk),
        .i_en  (w_en[ST_LAB +: LAB_STAGES]),
        .i_t   (w_tz),
        .o_f   (w_fz)
    );

    rcl_scale u_scale (
        .i_clk (i_clk),
        .i_en  (w_en[ST_SCL +: SCL_STAGES]),
        .i_fx  (w_fx),
        .i_fy  (w_fy),
        .i_fz  (w_fz),
        .o_lab (o_m_axis_tdata)
    );

    a_reset_empty : assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid right after reset");

    a_ready_through : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_axis_tready |-> o_s_axis_tready)
        else $error("input stalled while the output side is ready");

    a_light_nonneg : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> !o_m_axis_tdata[CH_W-1])
        else $error("negative lightness");

endmodule

// ----- dv/rgb_to_cielab_scaled_test.sv -----
// Testbench for the RGB to CIELAB converter: random and directed pixels checked against a predictor.
module rgb_to_cielab_scaled_test import rcl_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [15:0] blue_yellow;
        logic [15:0] green_red;
        logic [15:0] lightness;
    } lab_t;

    function automatic longint unsigned cube_root_rounded(longint unsigned n);
        longint unsigned c, trial, h;
        c = 0;
        for (int bit_i = 19; bit_i >= 0; bit_i--) begin
            trial = c | (64'd1 << bit_i);
            if (trial * trial * trial <= n) c = trial;
        end
        h = 2 * c + 1;
        if (h * h * h <= 8 * n) c++;
        return c;
    endfunction

    function automatic longint lab_curve(longint unsigned t);
        longint unsigned den, num;
        if (t * 1000000 > (64'd8856 << FRACTION_BITS))
            return longint'(cube_root_rounded(t << (3 * F_BITS - FRACTION_BITS)));
        den = 64'd1000000 << FRACTION_BITS;
        num = (64'd7787000 * t + (64'd137931 << FRACTION_BITS)) << F_BITS;
        return longint'((num + den / 2) / den);
    endfunction

    function automatic logic [15:0] scale_by_150(longint v);
        longint unsigned mag, den, q;
        mag = (v < 0) ? longint'(-v) : v;
        den = 64'd150 << F_BITS;
        q = ((mag << FRACTION_BITS) + den / 2) / den;
        if (v < 0) return (q > 32768) ? 16'h8000 : 16'(-longint'(q));
        return (q > 32767) ? 16'h7fff : 16'(q);
    endfunction

    function automatic longint unsigned coef(longint unsigned num, longint unsigned den);
        return ((num << COEF_BITS) + den / 2) / den;
    endfunction

    function automatic lab_t convert_pixel(logic [47:0] pix);
        longint unsigned m[3][3];
        longint unsigned acc;
        longint ch[3], fv[3];
        lab_t r;
        m[0] = '{coef(4124240, 9504670), coef(3575790, 9504670), coef(1804640, 9504670)};
        m[1] = '{coef(2126560, 10000000), coef(7151580, 10000000), coef(721856, 10000000)};
        m[2] = '{coef(193324, 10889690), coef(1191930, 10889690), coef(9504440, 10889690)};
        for (int i = 0; i < 3; i++) ch[i] = pix[16*i +: 16];
        for (int i = 0; i < 3; i++) begin
            acc = 64'd1 << (COEF_BITS - 1);
            for (int j = 0; j < 3; j++) acc += m[i][j] * ch[j];
            fv[i] = lab_curve(acc >> COEF_BITS);
        end
        r.lightness   = scale_by_150(116 * fv[1] - (64'sd16 << F_BITS));
        r.green_red   = scale_by_150(500 * (fv[0] - fv[1]));
        r.blue_yellow = scale_by_150(200 * (fv[1] - fv[2]));
        return r;
    endfunction

    class lab_scoreboard;
        lab_t pending[$];
        int   errors = 0;

        function void note_pixel(logic [47:0] pix);
            pending.push_back(convert_pixel(pix));
        endfunction

        function void check_lab(lab_t got);
            lab_t want;
            if (pending.size() == 0) begin
                report("unexpected output", '0, got);
                return;
            end
            want = pending.pop_front();
            if (want.lightness !== got.lightness) report("lightness", want, got);
            if (want.green_red !== got.green_red) report("green_red", want, got);
            if (want.blue_yellow !== got.blue_yellow) report("blue_yellow", want, got);
        endfunction

        function void report(string what, lab_t want, lab_t got);
            errors++;
            if (errors <= 10)
                $display("Mismatch %s: expected %h actual %h", what, want, got);
        endfunction
    endclass

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_s_axis_tvalid = 0;
    logic [47:0] i_s_axis_tdata = '0;
    logic        i_m_axis_tready = 0;
    logic        o_s_axis_tready, o_m_axis_tvalid;
    logic [47:0] o_m_axis_tdata;

    lab_scoreboard board = new();
    int  cycle_count = 0;
    int  hold_cycles = 0;
    bit  hold_done = 0;
    bit  stim_done = 0;

    rgb_to_cielab_scaled uut (.*);

    always begin
        #4 i_clk = 1;
        #4 i_clk = 0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 400000) begin
            $display("Simulation FAILED");
            $finish;
        end
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) board.check_lab(o_m_axis_tdata);
    end

    function automatic logic [15:0] rand_channel();
        case ($urandom_range(0, 7))
            0: return 16'($urandom_range(0, 300));
            1: return 16'($urandom_range(32700, 32768));
            2: return 16'($urandom_range(32769, 65535));
            default: return 16'($urandom_range(0, 32768));
        endcase
    endfunction

    task automatic send_pixel(logic [47:0] pix);
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 11) : 0;
        if (gap > 0) begin
            i_s_axis_tvalid <= 0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_axis_tvalid <= 1;
        i_s_axis_tdata  <= pix;
        do @(posedge i_clk); while (!o_s_axis_tready);
        board.note_pixel(pix);
        @(negedge i_clk);
    endtask

    task automatic drain();
        i_s_axis_tvalid <= 0;
        while (board.pending.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    initial begin
        logic [15:0] d[6];
        d = '{16'd0, 16'd32768, 16'd65535, 16'd1, 16'd290, 16'd16384};
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1;
        foreach (d[k]) send_pixel({d[k], d[k], d[k]});
        send_pixel({16'd0, 16'd0, 16'd32768});
        send_pixel({16'd0, 16'd32768, 16'd0});
        send_pixel({16'd32768, 16'd0, 16'd0});
        send_pixel({16'd65535, 16'd0, 16'd0});
        send_pixel({16'd0, 16'd0, 16'd65535});
        send_pixel({16'd266, 16'd266, 16'd266});
        send_pixel({16'd267, 16'd267, 16'd267});
        send_pixel({16'hAAAA, 16'h5555, 16'hFFFF});
        drain();
        for (int n = 0; n < 1750; n++) begin
            if (n == 900) drain();
            send_pixel({rand_channel(), rand_channel(), rand_channel()});
        end
        i_s_axis_tvalid <= 0;
        stim_done = 1;
    end

    initial begin
        int wait_n;
        i_m_axis_tready = 0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (!hold_done && cycle_count > 600) begin
                hold_done = 1;
                hold_cycles = 200;
            end
            if (hold_cycles > 0) begin
                i_m_axis_tready <= 0;
                repeat (hold_cycles) @(negedge i_clk);
                hold_cycles = 0;
            end
            wait_n = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 11) : 0;
            if (wait_n > 0) begin
                i_m_axis_tready <= 0;
                repeat (wait_n) @(negedge i_clk);
            end
            i_m_axis_tready <= 1;
            do @(posedge i_clk); while (!o_m_axis_tvalid);
        end
    end

    initial begin
        while (!stim_done) @(posedge i_clk);
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        if (board.errors == 0 && board.pending.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule
